### rtl/saes_pkg.sv
package saes_pkg;

  localparam int unsigned BlockW = 16;
  localparam int unsigned KeyW   = 16;

  localparam logic [7:0] Rcon1 = 8'h80;
  localparam logic [7:0] Rcon2 = 8'h30;

  localparam logic [3:0] EncMix0 = 4'h1;
  localparam logic [3:0] EncMix1 = 4'h4;
  localparam logic [3:0] DecMix0 = 4'h9;
  localparam logic [3:0] DecMix1 = 4'h2;

  // x^4 + x + 1 with the x^4 term dropped
  localparam logic [3:0] GfPoly = 4'h3;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [BlockW-1:0] rk0;
    logic [BlockW-1:0] rk1;
    logic [BlockW-1:0] rk2;
  } round_keys_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'h9;
      4'h1: r = 4'h4;
      4'h2: r = 4'hA;
      4'h3: r = 4'hB;
      4'h4: r = 4'hD;
      4'h5: r = 4'h1;
      4'h6: r = 4'h8;
      4'h7: r = 4'h5;
      4'h8: r = 4'h6;
      4'h9: r = 4'h2;
      4'hA: r = 4'h0;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'hE;
      4'hE: r = 4'hF;
      default: r = 4'h7;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hA;
      4'h1: r = 4'h5;
      4'h2: r = 4'h9;
      4'h3: r = 4'hB;
      4'h4: r = 4'h1;
      4'h5: r = 4'h7;
      4'h6: r = 4'h8;
      4'h7: r = 4'hF;
      4'h8: r = 4'h6;
      4'h9: r = 4'h0;
      4'hA: r = 4'h2;
      4'hB: r = 4'h3;
      4'hC: r = 4'hC;
      4'hD: r = 4'h4;
      4'hE: r = 4'hD;
      default: r = 4'hE;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] r;
    logic [3:0] aa;
    r  = '0;
    aa = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) begin
        r = r ^ aa;
      end
      aa = {aa[2:0], 1'b0} ^ (aa[3] ? GfPoly : 4'h0);
    end
    return r;
  endfunction

  function automatic logic [BlockW-1:0] sub_fwd(input logic [BlockW-1:0] s);
    return {sbox_fwd(s[15:12]), sbox_fwd(s[11:8]), sbox_fwd(s[7:4]), sbox_fwd(s[3:0])};
  endfunction

  function automatic logic [BlockW-1:0] sub_inv(input logic [BlockW-1:0] s);
    return {sbox_inv(s[15:12]), sbox_inv(s[11:8]), sbox_inv(s[7:4]), sbox_inv(s[3:0])};
  endfunction

  function automatic logic [BlockW-1:0] swap_rows(input logic [BlockW-1:0] s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  function automatic logic [BlockW-1:0] mix_cols(input logic [BlockW-1:0] s,
                                                 input logic [3:0] m0,
                                                 input logic [3:0] m1);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic [3:0] d;
    a = gf_mul(m0, s[15:12]) ^ gf_mul(m1, s[11:8]);
    b = gf_mul(m1, s[15:12]) ^ gf_mul(m0, s[11:8]);
    c = gf_mul(m0, s[7:4]) ^ gf_mul(m1, s[3:0]);
    d = gf_mul(m1, s[7:4]) ^ gf_mul(m0, s[3:0]);
    return {a, b, c, d};
  endfunction

  function automatic logic [7:0] key_word(input logic [7:0] w, input logic [7:0] rc);
    return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rc;
  endfunction

  function automatic round_keys_t expand_key(input logic [KeyW-1:0] k);
    round_keys_t rk;
    logic [7:0] w2;
    logic [7:0] w3;
    logic [7:0] w4;
    logic [7:0] w5;
    w2 = k[15:8] ^ key_word(k[7:0], Rcon1);
    w3 = w2 ^ k[7:0];
    w4 = w2 ^ key_word(w3, Rcon2);
    w5 = w4 ^ w3;
    rk.rk0 = k;
    rk.rk1 = {w2, w3};
    rk.rk2 = {w4, w5};
    return rk;
  endfunction

endpackage

### rtl/saes_key_sched.sv
module saes_key_sched (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [saes_pkg::KeyW-1:0]  cfg_cipher_key,
  output saes_pkg::round_keys_t      round_keys
);
  import saes_pkg::*;

  round_keys_t keys_r;
  round_keys_t keys_nxt;

  assign cfg_ready = 1'b1;

  // expand at write time so the datapath only sees registered round keys
  always_comb begin
    keys_nxt = keys_r;
    if (cfg_valid && cfg_ready) begin
      keys_nxt = expand_key(cfg_cipher_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= expand_key('0);
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign round_keys = keys_r;

endmodule

### rtl/saes_block_cipher.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_opcode, in_block_in
// out     | output    | out_valid / out_stall| out_block_out
// cfg     | input     | cfg_valid / cfg_ready| cfg_cipher_key
//
// three register stages, one transaction accepted per cycle while in_stall is low
// encrypting, stage 1 adds rk0 and substitutes, stage 2 swaps rows, mixes columns
// and adds rk1, stage 3 substitutes, swaps rows and adds rk2
// cfg_ready is always high; round keys are expanded and registered on the write
// synchronous active-low reset empties the pipeline and sets the key to zero
// out_stall holds full stages back to the first bubble; a bubble still fills
module saes_block_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [saes_pkg::BlockW-1:0] in_block_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [saes_pkg::BlockW-1:0] out_block_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [saes_pkg::KeyW-1:0]   cfg_cipher_key
);
  import saes_pkg::*;

  round_keys_t rk;

  logic              v1_r, v2_r, v3_r;
  opcode_t           op1_r, op2_r;
  logic [BlockW-1:0] s1_r, s2_r, s3_r;
  logic [BlockW-1:0] s1_nxt, s2_nxt, s3_nxt;
  logic              adv1, adv2, adv3;

  saes_key_sched u_key_sched (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cipher_key (cfg_cipher_key),
    .round_keys     (rk)
  );

  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    if (opcode_t'(in_opcode) == OP_ENCRYPT) begin
      s1_nxt = sub_fwd(in_block_in ^ rk.rk0);
    end else begin
      s1_nxt = sub_inv(swap_rows(in_block_in ^ rk.rk2));
    end
  end

  always_comb begin
    if (op1_r == OP_ENCRYPT) begin
      s2_nxt = mix_cols(swap_rows(s1_r), EncMix0, EncMix1) ^ rk.rk1;
    end else begin
      s2_nxt = mix_cols(s1_r ^ rk.rk1, DecMix0, DecMix1);
    end
  end

  always_comb begin
    if (op2_r == OP_ENCRYPT) begin
      s3_nxt = swap_rows(sub_fwd(s2_r)) ^ rk.rk2;
    end else begin
      s3_nxt = sub_inv(swap_rows(s2_r)) ^ rk.rk0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r  <= s1_nxt;
      op1_r <= opcode_t'(in_opcode);
    end
    if (adv2 && v1_r) begin
      s2_r  <= s2_nxt;
      op2_r <= op1_r;
    end
    if (adv3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid     = v3_r;
  assign out_block_out = s3_r;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_flow_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!v1_r && !v2_r && !v3_r))
    else $error("pipeline not empty after reset");

  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv2) |=> (v1_r && $stable(s1_r)))
    else $error("stage 1 lost a held transaction");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted transaction missing from stage 1");

endmodule
